// ===== rtl/utfpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpn_pkg
// Types and constants shared by the printable UTF-8 name checker.
// ----------------------------------------------------------------------------
package utfpn_pkg;

   localparam int unsigned CountW   = 17;
   localparam int unsigned MaxLenW  = 16;
   localparam int unsigned CpW      = 21;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 16;

   localparam logic [CountW-1:0] CountMax = 17'h1FFFF;
   localparam logic [MaxLenW-1:0] MaxLenReset = 16'd32;

   localparam logic [CpW-1:0] CpMin3     = 21'h000800;
   localparam logic [CpW-1:0] CpMin4     = 21'h010000;
   localparam logic [CpW-1:0] CpSurroLo  = 21'h00D800;
   localparam logic [CpW-1:0] CpSurroHi  = 21'h00DFFF;
   localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
   localparam logic [CpW-1:0] CpC1Max    = 21'h00009F;

   localparam logic [7:0] ContMask  = 8'hC0;
   localparam logic [7:0] ContValue = 8'h80;

   // configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_NAME_RULES  = 2'd0,
      CSR_MAX_LEN     = 2'd1,
      CSR_ALLOW_EMPTY = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      REASON_OK        = 3'd0,
      REASON_TOO_LONG  = 3'd1,
      REASON_EMPTY     = 3'd2,
      REASON_FORBIDDEN = 3'd3,
      REASON_CONTROL   = 3'd4,
      REASON_MALFORMED = 3'd5
   } reason_type;

   typedef struct packed {
      logic             name_rules;
      logic [MaxLenW-1:0] max_len;
      logic             allow_empty;
   } config_type;

   typedef struct packed {
      logic [1:0]        pending;
      logic [2:0]        seq_len;
      logic [CpW-1:0]    code_point;
      logic [CountW-1:0] byte_count;
      reason_type        first_error;
      logic              forbidden_seen;
      logic              terminated;
   } text_state_type;

   localparam text_state_type TextStateClear = '{
      pending:        2'd0,
      seq_len:        3'd0,
      code_point:     '0,
      byte_count:     '0,
      first_error:    REASON_OK,
      forbidden_seen: 1'b0,
      terminated:     1'b0
   };

endpackage

// ===== rtl/utfpn_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpn channel interfaces
// Valid/ready channels for byte requests and text verdicts.
// ----------------------------------------------------------------------------
interface utfpn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last;

   modport source (output valid, output data_byte, output byte_present, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_present, input last,
                   output ready);
endinterface

interface utfpn_rsp_if;
   logic       valid;
   logic       ready;
   logic       text_ok;
   logic [2:0] fail_reason;

   modport source (output valid, output text_ok, output fail_reason, input ready);
   modport sink   (input valid, input text_ok, input fail_reason, output ready);
endinterface

// ===== rtl/utfpn_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpn_step
// Per-byte decode: next text state and the verdict for a closing transaction.
// ----------------------------------------------------------------------------
module utfpn_step (
   input  utfpn_pkg::config_type     cfg,
   input  utfpn_pkg::text_state_type cur,
   input  logic [7:0]                data_byte,
   input  logic                      byte_present,
   output utfpn_pkg::text_state_type nxt,
   output utfpn_pkg::reason_type     verdict
);

   logic [utfpn_pkg::CpW-1:0] cp_shift;
   logic                      cp_malformed;
   logic                      cp_control;
   utfpn_pkg::reason_type     stream_err;

   // code point after appending this continuation byte
   assign cp_shift = {cur.code_point[utfpn_pkg::CpW-7:0], data_byte[5:0]};

   assign cp_malformed = (cur.seq_len == 3'd3 && cp_shift < utfpn_pkg::CpMin3) ||
                         (cur.seq_len == 3'd4 && cp_shift < utfpn_pkg::CpMin4) ||
                         (cp_shift >= utfpn_pkg::CpSurroLo &&
                          cp_shift <= utfpn_pkg::CpSurroHi) ||
                         (cp_shift > utfpn_pkg::CpMax);
   assign cp_control   = (cp_shift <= utfpn_pkg::CpC1Max);

   always_comb begin
      nxt = cur;
      if (byte_present && !cur.terminated) begin
         if (cfg.name_rules && data_byte == 8'h00) begin
            nxt.terminated = 1'b1;
            if (cur.pending != 2'd0) begin
               nxt.pending = 2'd0;
               if (cur.first_error == utfpn_pkg::REASON_OK)
                  nxt.first_error = utfpn_pkg::REASON_MALFORMED;
            end
         end else begin
            if (cur.byte_count != utfpn_pkg::CountMax)
               nxt.byte_count = cur.byte_count + 1'b1;
            case (data_byte) inside
               8'h2B, 8'h23, 8'h2F, 8'h22, 8'h5C: nxt.forbidden_seen = 1'b1;
               default: ;
            endcase
            if (cur.pending != 2'd0) begin
               if ((data_byte & utfpn_pkg::ContMask) == utfpn_pkg::ContValue) begin
                  nxt.code_point = cp_shift;
                  nxt.pending    = cur.pending - 2'd1;
                  if (cur.pending == 2'd1 && cur.first_error == utfpn_pkg::REASON_OK) begin
                     if (cp_malformed)
                        nxt.first_error = utfpn_pkg::REASON_MALFORMED;
                     else if (cp_control)
                        nxt.first_error = utfpn_pkg::REASON_CONTROL;
                  end
               end else begin
                  // bad continuation: the byte is eaten with the broken sequence
                  nxt.pending = 2'd0;
                  if (cur.first_error == utfpn_pkg::REASON_OK)
                     nxt.first_error = utfpn_pkg::REASON_MALFORMED;
               end
            end else begin
               case (data_byte) inside
                  [8'hC2:8'hDF]: begin
                     nxt.pending    = 2'd1;
                     nxt.seq_len    = 3'd2;
                     nxt.code_point = {16'd0, data_byte[4:0]};
                  end
                  [8'hE0:8'hEF]: begin
                     nxt.pending    = 2'd2;
                     nxt.seq_len    = 3'd3;
                     nxt.code_point = {17'd0, data_byte[3:0]};
                  end
                  [8'hF0:8'hF4]: begin
                     nxt.pending    = 2'd3;
                     nxt.seq_len    = 3'd4;
                     nxt.code_point = {18'd0, data_byte[2:0]};
                  end
                  [8'h80:8'hC1], [8'hF5:8'hFF]: begin
                     if (cur.first_error == utfpn_pkg::REASON_OK)
                        nxt.first_error = utfpn_pkg::REASON_MALFORMED;
                  end
                  [8'h00:8'h1F], 8'h7F: begin
                     if (cur.first_error == utfpn_pkg::REASON_OK)
                        nxt.first_error = utfpn_pkg::REASON_CONTROL;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // verdict from the updated state
   always_comb begin
      stream_err = nxt.first_error;
      if (stream_err == utfpn_pkg::REASON_OK && nxt.pending != 2'd0)
         stream_err = utfpn_pkg::REASON_MALFORMED;
      verdict = stream_err;
      if (cfg.name_rules) begin
         if (nxt.byte_count > {1'b0, cfg.max_len})
            verdict = utfpn_pkg::REASON_TOO_LONG;
         else if (nxt.byte_count == '0)
            verdict = cfg.allow_empty ? utfpn_pkg::REASON_OK : utfpn_pkg::REASON_EMPTY;
         else if (nxt.forbidden_seen)
            verdict = utfpn_pkg::REASON_FORBIDDEN;
      end
   end

endmodule

// ===== rtl/utf8_printable_name_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_printable_name_checker
// Streams the bytes of one text and returns one pass/fail verdict per text.
// ----------------------------------------------------------------------------
// Takes one byte transaction every clock cycle unless a held verdict stalls
// it. Each accepted transaction updates the per-text decode state (open UTF-8
// sequence, saturating byte count, first stream error, forbidden-character and
// NUL flags) through one shallow combinational step. The transaction with
// last set has its verdict registered in the output register, which holds it
// until the sink takes it; a new byte is accepted in the same cycle the
// verdict leaves, so back-to-back texts run at one transaction per cycle
// while the sink is ready. The user must write configuration (name_rules,
// max_len, allow_empty) through the csr_ port only while no text is in flight;
// the block does not enforce this. Indexes past the list are ignored.
// ----------------------------------------------------------------------------
module utf8_printable_name_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   utfpn_req_if.sink                            req,
   utfpn_rsp_if.source                          rsp,
   input  logic                                 csr_we,
   input  logic [utfpn_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [utfpn_pkg::CsrDataW-1:0]       csr_wdata
);

   utfpn_pkg::config_type     cfg_ff;
   utfpn_pkg::text_state_type state_ff;
   utfpn_pkg::text_state_type state_in;
   utfpn_pkg::text_state_type step_nxt;
   utfpn_pkg::reason_type     step_verdict;

   logic                  rsp_valid_ff;
   logic                  text_ok_ff;
   utfpn_pkg::reason_type fail_reason_ff;
   logic                  req_take;

   // output register frees up when empty or being drained this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_rules  <= 1'b0;
         cfg_ff.max_len     <= utfpn_pkg::MaxLenReset;
         cfg_ff.allow_empty <= 1'b0;
      end else if (csr_we) begin
         case (utfpn_pkg::csr_index_type'(csr_index))
            utfpn_pkg::CSR_NAME_RULES:  cfg_ff.name_rules  <= csr_wdata[0];
            utfpn_pkg::CSR_MAX_LEN:     cfg_ff.max_len     <= csr_wdata;
            utfpn_pkg::CSR_ALLOW_EMPTY: cfg_ff.allow_empty <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   utfpn_step u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .data_byte    (req.data_byte),
      .byte_present (req.byte_present),
      .nxt          (step_nxt),
      .verdict      (step_verdict)
   );

   // text state: hold when idle, clear after the closing transaction
   always_comb begin
      state_in = state_ff;
      if (req_take)
         state_in = req.last ? utfpn_pkg::TextStateClear : step_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= utfpn_pkg::TextStateClear;
      else
         state_ff <= state_in;
   end

   // verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && req.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req.last) begin
         text_ok_ff     <= (step_verdict == utfpn_pkg::REASON_OK);
         fail_reason_ff <= step_verdict;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.text_ok     = text_ok_ff;
   assign rsp.fail_reason = fail_reason_ff;

endmodule
